### rtl/core/bpru_pkg.sv
// shared constants and types for the bmp pixel row unpacker
package bpru_pkg;

    // default sizes
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_ROW_PIXELS_DEF  = 4096;

    // row layout
    localparam int ROW_ALIGN = 4;
    localparam int BGR_BYTES = 3;

    // port widths
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    typedef logic                  t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [S_DATA_W-1:0]   t_s_data;
    typedef logic [M_DATA_W-1:0]   t_m_data;

    // register indexes
    localparam t_cfg_addr REG_PIXEL_FORMAT = 1'b0;
    localparam t_cfg_addr REG_ROW_WIDTH    = 1'b1;

    // pixel formats
    localparam logic FMT_PALETTE = 1'b0;
    localparam logic FMT_BGR     = 1'b1;

    // input word kinds
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_DATA      = 1'b1;

endpackage

### rtl/core/bmp_pixel_row_unpacker_core.sv
// bmp pixel row unpacker: byte stream in, rgb pixels out
//
// Takes the pixel area of a bmp image one byte per word and returns one rgb
// word per pixel, tlast marking the last pixel of each row. Rows are padded
// to a multiple of four bytes; padding bytes are dropped. In palette mode each
// byte looks up a palette entry that earlier palette-write words (tuser low)
// loaded; an index at or above PALETTE_ENTRIES reads as black and its write is
// ignored, and an entry never written reads as undefined. In bgr mode three
// bytes blue, green, red make one pixel, given out with the red byte. The
// block takes one word every cycle while the output is not stalled; a pixel
// passes stage one, with the registered read of the palette memory, and
// then the output register. Any configuration write restarts the row; the
// row width is clamped to 1..MAX_ROW_PIXELS and the per-row byte counts are
// worked out when a register is written, so a word may follow a write in
// the next cycle.
module bmp_pixel_row_unpacker_core #(
    parameter int PALETTE_ENTRIES = bpru_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_ROW_PIXELS  = bpru_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  bpru_pkg::t_cfg_addr i_cfg_addr,
    input  bpru_pkg::t_cfg_data i_cfg_data,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: data_byte, palette_index, palette_red, palette_green, palette_blue
    input  bpru_pkg::t_s_data   s_axis_tdata,
    // tuser: func
    input  logic                s_axis_tuser,
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: red, green, blue
    output bpru_pkg::t_m_data   m_axis_tdata,
    // tlast: row_end
    output logic                m_axis_tlast
);
    import bpru_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int WW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int CW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int PW = $clog2(BGR_BYTES * MAX_ROW_PIXELS + ROW_ALIGN);

    typedef enum logic [1:0] {
        PH_BLUE,
        PH_GREEN,
        PH_RED
    } t_phase;

    // stage one contents, waiting for the output register
    typedef struct packed {
        logic          use_pal;
        logic          idx_ok;
        logic          last;
        logic [23:0]   rgb;
    } t_s1;

    // configuration and derived row layout
    logic            r_fmt, n_fmt;
    logic [WW-1:0]   r_width, n_width;
    logic [PW-1:0]   r_last_pos, n_last_pos;
    logic [CW-1:0]   cfg_ext;
    logic [PW-1:0]   n_byte_width;
    logic [PW-1:0]   pad_last;

    // row state
    logic [PW-1:0]   r_pos, n_pos;
    t_phase          r_phase, n_phase;
    logic [15:0]     r_held, n_held;

    // input word fields
    logic            in_func;
    logic [7:0]      in_byte;
    logic [7:0]      in_pidx;
    logic [7:0]      in_pr, in_pg, in_pb;

    logic            s_acc;
    logic            is_pix, is_last, is_wrap, emit;
    logic            rd_ok, wr_ok;

    // palette memory
    logic [23:0]     r_pal [PALETTE_ENTRIES];
    logic [23:0]     r_mem_q;

    // pipeline
    logic            r_s1_valid;
    t_s1             r_s1, n_s1;
    logic            s1_move;
    logic            r_out_valid;
    logic [23:0]     r_out_rgb;
    logic            r_out_last;
    logic [23:0]     s1_rgb;

    assign in_byte = s_axis_tdata[7:0];
    assign in_pidx = s_axis_tdata[15:8];
    assign in_pr   = s_axis_tdata[23:16];
    assign in_pg   = s_axis_tdata[31:24];
    assign in_pb   = s_axis_tdata[39:32];
    assign in_func = s_axis_tuser;

    // ---------------------------------------------------------------
    // configuration: clamp width, precompute last pixel byte position
    // ---------------------------------------------------------------
    assign cfg_ext = CW'(i_cfg_data);

    always_comb begin
        n_fmt   = r_fmt;
        n_width = r_width;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PIXEL_FORMAT: begin
                    n_fmt = i_cfg_data[0];
                end
                REG_ROW_WIDTH: begin
                    if (cfg_ext == '0) begin
                        n_width = WW'(1);
                    end else if (cfg_ext > CW'(MAX_ROW_PIXELS)) begin
                        n_width = WW'(MAX_ROW_PIXELS);
                    end else begin
                        n_width = WW'(cfg_ext);
                    end
                end
                default: begin
                    n_width = r_width;
                end
            endcase
        end
        // bgr rows hold three bytes per pixel
        if (n_fmt == FMT_BGR) begin
            n_byte_width = (PW'(n_width) << 1) + PW'(n_width);
        end else begin
            n_byte_width = PW'(n_width);
        end
        n_last_pos = n_byte_width - PW'(1);
    end

    // last padded byte: last pixel byte rounded up to the 4-byte boundary
    assign pad_last = r_last_pos | PW'(ROW_ALIGN - 1);

    // ---------------------------------------------------------------
    // row walk
    // ---------------------------------------------------------------
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign is_pix  = (r_pos <= r_last_pos);
    assign is_last = (r_pos == r_last_pos);
    assign is_wrap = (r_pos == pad_last);
    assign emit    = is_pix && ((r_fmt == FMT_PALETTE) || (r_phase == PH_RED));

    assign rd_ok = ({1'b0, in_byte} < 9'(PALETTE_ENTRIES));
    assign wr_ok = ({1'b0, in_pidx} < 9'(PALETTE_ENTRIES));

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_held  = r_held;
        if (i_cfg_we) begin
            // any register write restarts the row
            n_pos   = '0;
            n_phase = PH_BLUE;
            n_held  = '0;
        end else if (s_acc && (in_func == FUNC_DATA)) begin
            if (is_pix && (r_fmt == FMT_BGR)) begin
                case (r_phase)
                    PH_BLUE: begin
                        n_held[7:0] = in_byte;
                        n_phase     = PH_GREEN;
                    end
                    PH_GREEN: begin
                        n_held[15:8] = in_byte;
                        n_phase      = PH_RED;
                    end
                    default: begin
                        n_phase = PH_BLUE;
                    end
                endcase
            end
            if (is_wrap) begin
                n_pos   = '0;
                n_phase = PH_BLUE;
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_BGR;
            r_width    <= WW'(1);
            r_last_pos <= PW'(BGR_BYTES - 1);
            r_pos      <= '0;
            r_phase    <= PH_BLUE;
            r_held     <= '0;
        end else begin
            r_fmt      <= n_fmt;
            r_width    <= n_width;
            r_last_pos <= n_last_pos;
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_held     <= n_held;
        end
    end

    // ---------------------------------------------------------------
    // palette memory, one write or one registered read per word
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            if (in_func == FUNC_PAL_WRITE) begin
                if (wr_ok) begin
                    r_pal[in_pidx[AW-1:0]] <= {in_pr, in_pg, in_pb};
                end
            end else begin
                r_mem_q <= r_pal[in_byte[AW-1:0]];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage one and output register
    // ---------------------------------------------------------------
    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;

    always_comb begin
        n_s1.use_pal = (r_fmt == FMT_PALETTE);
        n_s1.idx_ok  = rd_ok;
        n_s1.last    = is_last;
        // red from this byte, green and blue held from the two before
        n_s1.rgb     = {r_held[7:0], r_held[15:8], in_byte};
    end

    // palette entries store red in the top byte, the bus wants it lowest
    always_comb begin
        if (r_s1.use_pal) begin
            if (r_s1.idx_ok) begin
                s1_rgb = {r_mem_q[7:0], r_mem_q[15:8], r_mem_q[23:16]};
            end else begin
                s1_rgb = '0;
            end
        end else begin
            s1_rgb = r_s1.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_acc && (in_func == FUNC_DATA) && emit;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_rgb  <= s1_rgb;
            r_out_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rgb;
    assign m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // an empty stage one never holds back the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("input stalled with stage one empty");

    // the byte position never leaves the padded row
    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= pad_last)
        else $error("row position past padded row end");

    // the last pixel byte of a bgr row closes a pixel
    a_bgr_row_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_func == FUNC_DATA) && is_last && (r_fmt == FMT_BGR)
            && !i_cfg_we) |-> (r_phase == PH_RED))
        else $error("bgr row ends inside a pixel");

endmodule
